[src/zsn_pkg.sv]
`default_nettype none

package zsn_pkg;

  // feature slots handled by a finish
  localparam int unsigned Features = 16;
  // a sample is dropped once its count reaches this
  localparam logic [15:0] MaxSamples = 16'hFFFF;
  // 1.0 in Q15.16
  localparam logic [30:0] OneQ16 = 31'd65536;

  typedef enum logic [2:0] {
    OP_ACC    = 3'd0,
    OP_FIN    = 3'd1,
    OP_NORM   = 3'd2,
    OP_DENORM = 3'd3,
    OP_LOAD   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_STAT   = 2'd0,
    KIND_NORM   = 2'd1,
    KIND_DENORM = 2'd2
  } kind_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic [3:0]         feature;
    logic signed [31:0] value;
    logic [30:0]        deviation_in;
  } zsn_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         feature_out;
    logic signed [31:0] result_value;
    logic [30:0]        deviation_out;
    logic               last;
  } zsn_out_t;

endpackage

`default_nettype wire

[src/zscore_stats_normalizer_unit.sv]
`default_nettype none

// Per-feature z-score statistics and conversion, signed Q15.16.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat is one command:
// accumulate a sample, finish the statistics, normalize, denormalize, or load a
// feature's mean and deviation. Output channel (out_valid_o / out_stall_i /
// out_data_o): one beat is one result. A finish gives 16 statistic records, the
// last one flagged; normalize and denormalize give one beat each.
// One command is worked at a time; in_stall_o is high while it runs.
// A finish works the features in turn: a 49-step mean division, a three-product
// square on the shared 32x32 multiplier, two 80-step divisions and a 40-step
// square root; the divisions and the root all run on one shift/subtract unit
// that also serves the normalize division.
// A result sits in the output register while the receiver stalls; a new
// command is taken meanwhile, and its own result waits until that beat goes.
// Reset clears all sums and counts, means to 0 and deviations to 1.0.
module zscore_stats_normalizer_unit import zsn_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire zsn_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output zsn_out_t      out_data_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MUL    = 12'b0000_0000_0010,
    S_ACC    = 12'b0000_0000_0100,
    S_DEN    = 12'b0000_0000_1000,
    S_NSTART = 12'b0000_0001_0000,
    S_FREAD  = 12'b0000_0010_0000,
    S_DIV    = 12'b0000_0100_0000,
    S_POST   = 12'b0000_1000_0000,
    S_SQ     = 12'b0001_0000_0000,
    S_SQRT   = 12'b0010_0000_0000,
    S_FWRITE = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_e;

  typedef enum logic [2:0] {
    PH_MEAN = 3'd0,
    PH_CORR = 3'd1,
    PH_VAR  = 3'd2,
    PH_ROOT = 3'd3,
    PH_NORM = 3'd4
  } phase_e;

  localparam logic [3:0] LastFeat = 4'(Features - 1);

  // saturate a sign and magnitude to 32 bits
  function automatic logic [31:0] sat_mag(input logic neg, input logic [79:0] q);
    logic big;
    big = |q[79:31];
    if (neg) begin
      sat_mag = (big && (q != 80'h8000_0000)) ? 32'h8000_0000 : 32'(-q[31:0]);
    end else begin
      sat_mag = big ? 32'h7FFF_FFFF : q[31:0];
    end
  endfunction

  function automatic logic [31:0] sat_s50(input logic signed [49:0] v);
    if (v > 50'sd2147483647) begin
      sat_s50 = 32'h7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      sat_s50 = 32'h8000_0000;
    end else begin
      sat_s50 = v[31:0];
    end
  endfunction

  state_e state_q, state_d;

  // statistic stores
  logic signed [47:0] sum_mem_q  [16];
  logic [63:0]        sqs_mem_q  [16];
  logic [15:0]        num_mem_q  [16];
  logic signed [31:0] mean_mem_q [16];
  logic [30:0]        dev_mem_q  [16];

  // command and working registers
  logic [2:0]         op_q;
  logic [3:0]         feat_q;
  logic signed [31:0] x_q;
  logic [15:0]        n_q;
  logic [47:0]        mag_q;
  logic               neg_q;
  logic [31:0]        mean_q;
  logic [30:0]        dev_q;
  logic [63:0]        prod_q;
  logic [95:0]        sq_q;
  logic [2:0]         sqstep_q;
  phase_e             phase_q;

  // shift/subtract unit
  logic [43:0] rem_q;
  logic [79:0] dq_q;
  logic [40:0] root_q;
  logic [30:0] dvs_q;
  logic [6:0]  it_q;

  zsn_out_t res_q, out_q;
  logic     out_valid_q;

  logic        accept, out_free, sqrt_mode, ge;
  logic [31:0] x_mag, mul_a, mul_b;
  logic [63:0] mul_p;
  logic [43:0] sh, tr, rem_n;
  logic [44:0] df;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign x_mag = x_q[31] ? 32'(-x_q) : x_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = x_mag;
    mul_b = (op_q == OP_ACC) ? x_mag : {1'b0, dev_mem_q[feat_q]};
    if (state_q == S_SQ) begin
      unique case (sqstep_q)
        3'd0: begin
          mul_a = mag_q[31:0];
          mul_b = mag_q[31:0];
        end
        3'd1: begin
          mul_a = {16'b0, mag_q[47:32]};
          mul_b = mag_q[31:0];
        end
        default: begin
          mul_a = {16'b0, mag_q[47:32]};
          mul_b = {16'b0, mag_q[47:32]};
        end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // one restoring step: a quotient bit, or a root bit from two radicand bits
  assign sqrt_mode = (state_q == S_SQRT);
  assign sh = sqrt_mode ? {rem_q[41:0], dq_q[79:78]} : {rem_q[42:0], dq_q[79]};
  assign tr = sqrt_mode ? {1'b0, root_q, 2'b01} : {13'b0, dvs_q};
  assign df = {1'b0, sh} - {1'b0, tr};
  assign ge = !df[44];
  assign rem_n = ge ? df[43:0] : sh;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_data_i.operation)
            OP_ACC, OP_DENORM: state_d = S_MUL;
            OP_FIN:            state_d = S_FREAD;
            OP_NORM:           state_d = S_NSTART;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_MUL:    state_d = (op_q == OP_ACC) ? S_ACC : S_DEN;
      S_ACC:    state_d = S_IDLE;
      S_DEN:    state_d = S_EMIT;
      S_NSTART: state_d = (dev_mem_q[feat_q] == '0) ? S_EMIT : S_DIV;
      S_FREAD:  state_d = (num_mem_q[feat_q] == '0) ? S_FWRITE : S_DIV;
      S_DIV:    state_d = (it_q == 7'd1) ? S_POST : S_DIV;
      S_POST: begin
        unique case (phase_q)
          PH_MEAN: state_d = (n_q < 16'd2) ? S_FWRITE : S_SQ;
          PH_CORR: state_d = S_DIV;
          PH_VAR:  state_d = S_SQRT;
          PH_ROOT: state_d = S_FWRITE;
          default: state_d = S_EMIT;
        endcase
      end
      S_SQ:     state_d = (sqstep_q == 3'd4) ? S_DIV : S_SQ;
      S_SQRT:   state_d = (it_q == 7'd1) ? S_POST : S_SQRT;
      S_FWRITE: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = (op_q == OP_FIN && feat_q != LastFeat) ? S_FREAD : S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // statistic stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        sum_mem_q[i]  <= '0;
        sqs_mem_q[i]  <= '0;
        num_mem_q[i]  <= '0;
        mean_mem_q[i] <= '0;
        dev_mem_q[i]  <= OneQ16;
      end
    end else begin
      if (state_q == S_IDLE && accept && in_data_i.operation == OP_LOAD) begin
        mean_mem_q[in_data_i.feature] <= in_data_i.value;
        dev_mem_q[in_data_i.feature]  <= in_data_i.deviation_in;
      end
      if (state_q == S_ACC && num_mem_q[feat_q] != MaxSamples) begin
        sum_mem_q[feat_q] <= sum_mem_q[feat_q] + 48'(x_q);
        sqs_mem_q[feat_q] <= sqs_mem_q[feat_q] + {16'b0, prod_q[63:16]};
        num_mem_q[feat_q] <= num_mem_q[feat_q] + 16'd1;
      end
      if (state_q == S_FWRITE) begin
        mean_mem_q[feat_q] <= mean_q;
        dev_mem_q[feat_q]  <= dev_q;
        sum_mem_q[feat_q]  <= '0;
        sqs_mem_q[feat_q]  <= '0;
        num_mem_q[feat_q]  <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    logic signed [47:0] s;
    logic [15:0]        n;
    logic signed [32:0] diff;
    logic [32:0]        dmag;
    logic [63:0]        rnd, corr, num, sqs;
    logic signed [49:0] sv;
    logic [30:0]        d;
    s    = sum_mem_q[feat_q];
    n    = num_mem_q[feat_q];
    d    = dev_mem_q[feat_q];
    sqs  = sqs_mem_q[feat_q];
    diff = 33'(x_q) - 33'(mean_mem_q[feat_q]);
    dmag = diff[32] ? 33'(-diff) : diff;
    rnd  = prod_q + 64'h8000;
    sv   = x_q[31] ? -$signed({2'b0, rnd[63:16]}) : $signed({2'b0, rnd[63:16]});
    sv   = sv + 50'(mean_mem_q[feat_q]);
    corr = (|dq_q[79:64]) ? '1 : dq_q[63:0];
    num  = (sqs > corr) ? sqs - corr : '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q   <= in_data_i.operation;
          feat_q <= (in_data_i.operation == OP_FIN) ? 4'd0 : in_data_i.feature;
          x_q    <= in_data_i.value;
        end
      end
      S_MUL: prod_q <= mul_p;
      S_DEN: begin
        res_q <= '{kind: KIND_DENORM, feature_out: feat_q, result_value: sat_s50(sv),
                   deviation_out: '0, last: 1'b1};
      end
      S_NSTART: begin
        neg_q <= diff[32];
        res_q <= '{kind: KIND_NORM, feature_out: feat_q,
                   result_value: (diff == '0) ? 32'd0 :
                                 (diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF),
                   deviation_out: '0, last: 1'b1};
        phase_q <= PH_NORM;
        rem_q   <= '0;
        dvs_q   <= d;
        it_q    <= 7'd49;
        dq_q    <= {{dmag, 16'b0} + 49'(d[30:1]), 31'b0};
      end
      S_FREAD: begin
        n_q    <= n;
        neg_q  <= s[47];
        mag_q  <= s[47] ? 48'(-s) : s;
        mean_q <= '0;
        dev_q  <= OneQ16;
        // mean division: (|sum| + n/2) / n
        phase_q <= PH_MEAN;
        rem_q   <= '0;
        dvs_q   <= {15'b0, n};
        it_q    <= 7'd49;
        dq_q    <= {49'(s[47] ? 48'(-s) : s) + 49'(n[15:1]), 31'b0};
      end
      S_DIV: begin
        rem_q <= rem_n;
        dq_q  <= {dq_q[78:0], ge};
        it_q  <= it_q - 7'd1;
      end
      S_POST: begin
        unique case (phase_q)
          PH_MEAN: begin
            mean_q   <= sat_mag(neg_q, dq_q);
            sqstep_q <= 3'd0;
          end
          PH_CORR: begin
            phase_q <= PH_VAR;
            rem_q   <= '0;
            dvs_q   <= {15'b0, n_q - 16'd1};
            it_q    <= 7'd80;
            dq_q    <= {num, 16'b0};
          end
          PH_VAR: begin
            phase_q <= PH_ROOT;
            rem_q   <= '0;
            root_q  <= '0;
            it_q    <= 7'd40;
          end
          PH_ROOT: begin
            if (|root_q[40:31]) begin
              dev_q <= 31'h7FFF_FFFF;
            end else if (root_q == '0) begin
              dev_q <= OneQ16;
            end else begin
              dev_q <= root_q[30:0];
            end
          end
          default: begin
            res_q.result_value <= sat_mag(neg_q, dq_q);
          end
        endcase
      end
      S_SQ: begin
        // |sum|^2 from three 32x32 products
        sqstep_q <= sqstep_q + 3'd1;
        prod_q   <= mul_p;
        unique case (sqstep_q)
          3'd0: sq_q <= '0;
          3'd1: sq_q <= {32'b0, prod_q};
          3'd2: sq_q <= sq_q + {prod_q[62:0], 33'b0};
          3'd3: sq_q <= sq_q + {prod_q[31:0], 64'b0};
          default: begin
            phase_q <= PH_CORR;
            rem_q   <= '0;
            dvs_q   <= {15'b0, n_q};
            it_q    <= 7'd80;
            dq_q    <= sq_q[95:16];
          end
        endcase
      end
      S_SQRT: begin
        rem_q  <= rem_n;
        dq_q   <= {dq_q[77:0], 2'b00};
        root_q <= {root_q[39:0], ge};
        it_q   <= it_q - 7'd1;
      end
      S_FWRITE: begin
        res_q <= '{kind: KIND_STAT, feature_out: feat_q, result_value: mean_q,
                   deviation_out: dev_q, last: (feat_q == LastFeat)};
      end
      S_EMIT: begin
        if (out_free) begin
          out_q <= res_q;
          if (op_q == OP_FIN) begin
            feat_q <= feat_q + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[src/zsn_checker.sv]
`default_nettype none

module zsn_checker import zsn_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire zsn_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire zsn_out_t out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // long commands block the input right after they are taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.operation == OP_NORM || in_data_i.operation == OP_FIN) |=> in_stall_o)
    else $error("input taken while a command runs");

  // conversions carry no deviation and always close their run
  a_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_STAT |->
    out_data_o.deviation_out == '0 && out_data_o.last)
    else $error("conversion beat with deviation or without last");

  // a finished deviation is never zero
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_STAT |-> out_data_o.deviation_out != '0)
    else $error("statistic record with zero deviation");

endmodule

bind zscore_stats_normalizer_unit zsn_checker u_zsn_checker (.*);

`default_nettype wire
